// ----- sv/slp_pkg.sv -----
// Shared constants and widths for the Steger line-center pipeline.
// No dependencies; imported by every module of the block.
package slp_pkg;

  // Geometry and fixed-point format
  localparam int COORD_BITS = 11;
  localparam int FRAC_BITS  = 8;
  localparam int OUT_BITS   = 20;
  localparam int SQRT_GUARD = 8;
  localparam int VEC_BITS   = 12;

  // Input field widths
  localparam int INT_W  = 8;
  localparam int GRAD_W = 9;
  localparam int SEC_W  = 10;

  // Discriminant and square-root datapath
  localparam int DIFF_W    = SEC_W + 1;
  localparam int D_W       = 2 * DIFF_W;
  localparam int RAD_W     = D_W + 2 * SQRT_GUARD;
  localparam int SQ_PER    = 2;
  localparam int SQ_STAGES = (RAD_W / 2 + SQ_PER - 1) / SQ_PER;
  localparam int ROOT_W    = SQ_STAGES * SQ_PER;
  localparam int RAD_PAD   = 2 * ROOT_W;
  localparam int REM_W     = ROOT_W + 1;

  // Direction vector and normalization
  localparam int V_W   = ROOT_W + 3;
  localparam int MAG_W = V_W - 1;
  localparam int SH_W  = $clog2(MAG_W - VEC_BITS + 1);
  localparam int VN_W  = VEC_BITS + 1;
  localparam int VEC_HALF = 2 ** (VEC_BITS - 1);

  // Projection, curvature and offset numerators
  localparam int P_W   = VN_W + GRAD_W + 1;
  localparam int SQR_W = 2 * VN_W;
  localparam int T_W   = SQR_W + SEC_W;
  localparam int Q_W   = T_W + 2;
  localparam int NX_W  = P_W + VN_W + 1;
  localparam int NUM_W = NX_W + FRAC_BITS + 1;

  // Reset value of the brightness threshold
  localparam logic [INT_W-1:0] THRESH_RESET = INT_W'(200);

endpackage

// ----- sv/slp_sqrt.sv -----
// Pipelined integer square root, SQ_PER result bits per register stage.
// Depends on slp_pkg for widths and stage count.
module slp_sqrt import slp_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [RAD_PAD-1:0] rad_i,
  output logic [ROOT_W-1:0]  root_o
);

  logic [REM_W-1:0]   rem_q [SQ_STAGES];
  logic [REM_W-1:0]   rem_d [SQ_STAGES];
  logic [ROOT_W-1:0]  root_q[SQ_STAGES];
  logic [ROOT_W-1:0]  root_d[SQ_STAGES];
  logic [RAD_PAD-1:0] rad_q [SQ_STAGES];
  logic [RAD_PAD-1:0] rad_d [SQ_STAGES];

  // Resolve SQ_PER root bits in each stage, two radicand bits per step
  always_comb begin
    logic [REM_W-1:0]   r;
    logic [ROOT_W-1:0]  t;
    logic [RAD_PAD-1:0] x;
    logic [ROOT_W+2:0]  cur;
    logic [ROOT_W+2:0]  trial;
    for (int s = 0; s < SQ_STAGES; s++) begin
      if (s == 0) begin
        r = '0;
        t = '0;
        x = rad_i;
      end else begin
        r = rem_q[s-1];
        t = root_q[s-1];
        x = rad_q[s-1];
      end
      for (int j = 0; j < SQ_PER; j++) begin
        cur   = {r, x[RAD_PAD-1:RAD_PAD-2]};
        trial = {1'b0, t, 2'b01};
        if (cur >= trial) begin
          r = REM_W'(cur - trial);
          t = {t[ROOT_W-2:0], 1'b1};
        end else begin
          r = cur[REM_W-1:0];
          t = {t[ROOT_W-2:0], 1'b0};
        end
        x = x << 2;
      end
      rem_d[s]  = r;
      root_d[s] = t;
      rad_d[s]  = x;
    end
  end

  // Advance all stages together
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < SQ_STAGES; s++) begin
        rem_q[s]  <= rem_d[s];
        root_q[s] <= root_d[s];
        rad_q[s]  <= rad_d[s];
      end
    end
  end

  assign root_o = root_q[SQ_STAGES-1];

endmodule

// ----- sv/slp_div.sv -----
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on slp_pkg; quotient is FRAC_BITS wide.
module slp_div import slp_pkg::*; (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [NUM_W-1:0]     num_i,
  input  logic [Q_W-1:0]       den_i,
  output logic [FRAC_BITS-1:0] quo_o
);

  logic [NUM_W-1:0]     rem_q[FRAC_BITS];
  logic [NUM_W-1:0]     rem_d[FRAC_BITS];
  logic [Q_W-1:0]       den_q[FRAC_BITS];
  logic [Q_W-1:0]       den_d[FRAC_BITS];
  logic [FRAC_BITS-1:0] quo_q[FRAC_BITS];
  logic [FRAC_BITS-1:0] quo_d[FRAC_BITS];

  // Trial subtract of the shifted divisor, most significant bit first
  always_comb begin
    logic [NUM_W-1:0]     r;
    logic [Q_W-1:0]       d;
    logic [FRAC_BITS-1:0] qv;
    logic [NUM_W-1:0]     sub;
    for (int s = 0; s < FRAC_BITS; s++) begin
      if (s == 0) begin
        r  = num_i;
        d  = den_i;
        qv = '0;
      end else begin
        r  = rem_q[s-1];
        d  = den_q[s-1];
        qv = quo_q[s-1];
      end
      sub = NUM_W'(d) << (FRAC_BITS - 1 - s);
      if (r >= sub) begin
        r = r - sub;
        qv[FRAC_BITS-1-s] = 1'b1;
      end
      rem_d[s] = r;
      den_d[s] = d;
      quo_d[s] = qv;
    end
  end

  // Advance all stages together
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < FRAC_BITS; s++) begin
        rem_q[s] <= rem_d[s];
        den_q[s] <= den_d[s];
        quo_q[s] <= quo_d[s];
      end
    end
  end

  assign quo_o = quo_q[FRAC_BITS-1];

endmodule

// ----- sv/steger_subpixel_line_point.sv -----
// Top level of the Steger subpixel line-center pipeline.
// Depends on slp_pkg, slp_sqrt and slp_div.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one pixel per transfer:
//   gray level, column, row, first derivatives and second derivatives.
//   Output channel (out_valid_o / out_stall_i) returns one result per pixel:
//   point_valid and the center in two's complement with FRAC_BITS fraction
//   bits; a pixel without a center returns point_valid 0 and zero centers.
//   The configuration channel (cfg_valid_i / cfg_ready_o) writes the
//   brightness threshold; it is always ready and should be written only
//   while the pipeline is empty.
// Pipeline: 29 register stages between the input transfer and out_valid_o
//   (input stage, discriminant stage, 10 square-root stages,
//   8 vector/curvature stages, 8 divider stages, output register).
// Throughput: one pixel per cycle unless out_stall_i holds a result; every stage advances together.
// Reset: clears all valid bits and loads the threshold with 200.
// Stall: while a result waits under out_stall_i the whole pipeline holds
//   and in_stall_o is raised; nothing is dropped or repeated.
module steger_subpixel_line_point import slp_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [INT_W-1:0]            cfg_intensity_threshold_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [INT_W-1:0]            intensity_i,
  input  logic [COORD_BITS-1:0]       column_i,
  input  logic [COORD_BITS-1:0]       row_i,
  input  logic signed [GRAD_W-1:0]    grad_x_i,
  input  logic signed [GRAD_W-1:0]    grad_y_i,
  input  logic signed [SEC_W-1:0]     second_xx_i,
  input  logic signed [SEC_W-1:0]     second_yy_i,
  input  logic signed [SEC_W-1:0]     second_xy_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        point_valid_o,
  output logic signed [OUT_BITS-1:0]  center_x_o,
  output logic signed [OUT_BITS-1:0]  center_y_o
);

  typedef struct packed {
    logic                     live;
    logic [COORD_BITS-1:0]    col;
    logic [COORD_BITS-1:0]    row;
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
    logic signed [SEC_W-1:0]  a;
    logic signed [SEC_W-1:0]  b;
    logic signed [SEC_W-1:0]  c;
  } sb_t;

  typedef struct packed {
    logic                  ok;
    logic                  sx;
    logic                  sy;
    logic [COORD_BITS-1:0] col;
    logic [COORD_BITS-1:0] row;
  } tail_t;

  logic adv;
  logic [INT_W-1:0] thr_q;

  // Valid bits
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q, v9_q, v10_q, vo_q;
  logic vs_q[SQ_STAGES];
  logic vd_q[FRAC_BITS];

  // Sideband
  sb_t   sb1_q, sb2_q, sb3_q, sb4_q, sb5_q, sb6_q, sb7_q, sb8_q, sb9_q;
  sb_t   sbs_q[SQ_STAGES];
  tail_t tl10_q;
  tail_t tld_q[FRAC_BITS];

  // Datapath registers
  logic [D_W-1:0]          dd2_q, bb4_q;
  logic [RAD_PAD-1:0]      rad_q;
  logic [ROOT_W-1:0]       root;
  logic signed [V_W-1:0]   vx3_q, vy3_q;
  logic [MAG_W-1:0]        mx4_q, my4_q;
  logic                    sx4_q, sy4_q;
  logic signed [VN_W-1:0]  vx5_q, vy5_q, vx6_q, vy6_q, vx7_q, vy7_q;
  logic signed [P_W-1:0]   pxx6_q, pyy6_q, p7_q;
  logic signed [SQR_W-1:0] sxx6_q, sxy6_q, syy6_q;
  logic signed [T_W-1:0]   t1_q, t2_q, t3_q;
  logic signed [Q_W-1:0]   q8_q;
  logic signed [NX_W-1:0]  nx8_q, ny8_q;
  logic [Q_W-1:0]          den9_q, den10_q;
  logic [NX_W-1:0]         mx9_q, my9_q;
  logic                    sx9_q, sy9_q, qz9_q;
  logic [NUM_W-1:0]        numx10_q, numy10_q;
  logic [FRAC_BITS-1:0]    qx, qy;
  logic                    pv_q;
  logic signed [OUT_BITS-1:0] cx_q, cy_q;

  // Combinational next values
  logic signed [DIFF_W-1:0] dd_c;
  logic signed [D_W-1:0]    dsq_c, bsq_c;
  logic signed [V_W-1:0]    vx3_d, vy3_d;
  logic [SH_W-1:0]          k_c;
  logic [MAG_W-1:0]         m_c;
  logic signed [VN_W-1:0]   vx5_d, vy5_d;
  logic [MAG_W-1:0]         shx_c, shy_c;
  logic signed [NX_W-1:0]   nxs_c, nys_c;
  logic                     ok_c;
  logic signed [OUT_BITS-1:0] ox_c, oy_c;

  // Whole pipeline advances unless a finished result is held
  assign adv         = !(vo_q && out_stall_i);
  assign in_stall_o  = !adv;
  assign cfg_ready_o = 1'b1;

  // Threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THRESH_RESET;
    end else if (cfg_valid_i) begin
      thr_q <= cfg_intensity_threshold_i;
    end
  end

  // Valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      v5_q  <= 1'b0;
      v6_q  <= 1'b0;
      v7_q  <= 1'b0;
      v8_q  <= 1'b0;
      v9_q  <= 1'b0;
      v10_q <= 1'b0;
      vo_q  <= 1'b0;
      for (int s = 0; s < SQ_STAGES; s++) vs_q[s] <= 1'b0;
      for (int s = 0; s < FRAC_BITS; s++) vd_q[s] <= 1'b0;
    end else if (adv) begin
      v1_q    <= in_valid_i;
      v2_q    <= v1_q;
      vs_q[0] <= v2_q;
      for (int s = 1; s < SQ_STAGES; s++) vs_q[s] <= vs_q[s-1];
      v3_q    <= vs_q[SQ_STAGES-1];
      v4_q    <= v3_q;
      v5_q    <= v4_q;
      v6_q    <= v5_q;
      v7_q    <= v6_q;
      v8_q    <= v7_q;
      v9_q    <= v8_q;
      v10_q   <= v9_q;
      vd_q[0] <= v10_q;
      for (int s = 1; s < FRAC_BITS; s++) vd_q[s] <= vd_q[s-1];
      vo_q    <= vd_q[FRAC_BITS-1];
    end
  end

  // Discriminant terms from the raw Hessian
  always_comb begin
    dd_c  = DIFF_W'(second_xx_i) - DIFF_W'(second_yy_i);
    dsq_c = D_W'(dd_c) * D_W'(dd_c);
    bsq_c = D_W'(second_xy_i) * D_W'(second_xy_i);
  end

  // Eigenvalue and raw direction vector
  always_comb begin
    logic signed [DIFF_W-1:0] sum;
    logic [SEC_W-1:0]         aa, ac;
    logic signed [V_W-1:0]    lam;
    sum   = DIFF_W'(sbs_q[SQ_STAGES-1].a) + DIFF_W'(sbs_q[SQ_STAGES-1].c);
    lam   = V_W'(sum) <<< SQRT_GUARD;
    lam   = (sum >= 0) ? lam + V_W'(root) : lam - V_W'(root);
    vx3_d = V_W'(sbs_q[SQ_STAGES-1].b) <<< (SQRT_GUARD + 1);
    vy3_d = lam - (V_W'(sbs_q[SQ_STAGES-1].a) <<< (SQRT_GUARD + 1));
    aa    = sbs_q[SQ_STAGES-1].a[SEC_W-1] ? SEC_W'(-sbs_q[SQ_STAGES-1].a)
                                          : SEC_W'(sbs_q[SQ_STAGES-1].a);
    ac    = sbs_q[SQ_STAGES-1].c[SEC_W-1] ? SEC_W'(-sbs_q[SQ_STAGES-1].c)
                                          : SEC_W'(sbs_q[SQ_STAGES-1].c);
    if (sbs_q[SQ_STAGES-1].b == '0) begin
      if (aa > ac || (aa == ac && sbs_q[SQ_STAGES-1].a >= sbs_q[SQ_STAGES-1].c)) begin
        vx3_d = V_W'(VEC_HALF);
        vy3_d = '0;
      end else begin
        vx3_d = '0;
        vy3_d = V_W'(VEC_HALF);
      end
    end
  end

  // Shift count that brings both components below the vector limit
  always_comb begin
    logic [VN_W-1:0] tx, ty;
    m_c = mx4_q | my4_q;
    k_c = '0;
    for (int i = VEC_BITS; i < MAG_W; i++) begin
      if (m_c[i]) k_c = SH_W'(i - VEC_BITS + 1);
    end
    shx_c = mx4_q >> k_c;
    shy_c = my4_q >> k_c;
    tx    = {1'b0, shx_c[VEC_BITS-1:0]};
    ty    = {1'b0, shy_c[VEC_BITS-1:0]};
    vx5_d = sx4_q ? -$signed(tx) : $signed(tx);
    vy5_d = sy4_q ? -$signed(ty) : $signed(ty);
  end

  // Move the offset numerators to the sign of a positive denominator
  always_comb begin
    nxs_c = q8_q[Q_W-1] ? -nx8_q : nx8_q;
    nys_c = q8_q[Q_W-1] ? -ny8_q : ny8_q;
  end

  // Offset must stay within half a pixel on both axes
  assign ok_c = sb9_q.live && !qz9_q
             && ((NUM_W'(mx9_q) << 1) <= NUM_W'(den9_q))
             && ((NUM_W'(my9_q) << 1) <= NUM_W'(den9_q));

  // Payload stages
  always_ff @(posedge clk_i) begin
    if (adv) begin
      // Input stage
      sb1_q <= '{live: intensity_i > thr_q, col: column_i, row: row_i,
                 gx: grad_x_i, gy: grad_y_i, a: second_xx_i, b: second_xy_i,
                 c: second_yy_i};
      dd2_q <= D_W'(dsq_c);
      bb4_q <= D_W'(bsq_c) << 2;
      // Radicand
      sb2_q <= sb1_q;
      rad_q <= RAD_PAD'({dd2_q + bb4_q, {(2 * SQRT_GUARD){1'b0}}});
      // Square-root sideband
      sbs_q[0] <= sb2_q;
      for (int s = 1; s < SQ_STAGES; s++) sbs_q[s] <= sbs_q[s-1];
      // Direction vector
      sb3_q <= sbs_q[SQ_STAGES-1];
      vx3_q <= vx3_d;
      vy3_q <= vy3_d;
      // Magnitudes
      sb4_q <= sb3_q;
      mx4_q <= vx3_q[V_W-1] ? MAG_W'(-vx3_q) : MAG_W'(vx3_q);
      my4_q <= vy3_q[V_W-1] ? MAG_W'(-vy3_q) : MAG_W'(vy3_q);
      sx4_q <= vx3_q[V_W-1];
      sy4_q <= vy3_q[V_W-1];
      // Normalized vector
      sb5_q <= sb4_q;
      vx5_q <= vx5_d;
      vy5_q <= vy5_d;
      // Products of the vector
      sb6_q  <= sb5_q;
      vx6_q  <= vx5_q;
      vy6_q  <= vy5_q;
      pxx6_q <= P_W'(vx5_q) * P_W'(sb5_q.gx);
      pyy6_q <= P_W'(vy5_q) * P_W'(sb5_q.gy);
      sxx6_q <= SQR_W'(vx5_q) * SQR_W'(vx5_q);
      sxy6_q <= SQR_W'(vx5_q) * SQR_W'(vy5_q);
      syy6_q <= SQR_W'(vy5_q) * SQR_W'(vy5_q);
      // Projection and curvature terms
      sb7_q <= sb6_q;
      vx7_q <= vx6_q;
      vy7_q <= vy6_q;
      p7_q  <= pxx6_q + pyy6_q;
      t1_q  <= T_W'(sxx6_q) * T_W'(sb6_q.a);
      t2_q  <= T_W'(sxy6_q) * T_W'(sb6_q.b);
      t3_q  <= T_W'(syy6_q) * T_W'(sb6_q.c);
      // Curvature and raw numerators
      sb8_q <= sb7_q;
      q8_q  <= Q_W'(t1_q) + (Q_W'(t2_q) <<< 1) + Q_W'(t3_q);
      nx8_q <= -(NX_W'(p7_q) * NX_W'(vx7_q));
      ny8_q <= -(NX_W'(p7_q) * NX_W'(vy7_q));
      // Denominator magnitude and numerator signs
      sb9_q  <= sb8_q;
      qz9_q  <= (q8_q == '0);
      den9_q <= q8_q[Q_W-1] ? Q_W'(-q8_q) : Q_W'(q8_q);
      sx9_q  <= nxs_c[NX_W-1];
      sy9_q  <= nys_c[NX_W-1];
      mx9_q  <= nxs_c[NX_W-1] ? NX_W'(-nxs_c) : NX_W'(nxs_c);
      my9_q  <= nys_c[NX_W-1] ? NX_W'(-nys_c) : NX_W'(nys_c);
      // Range check and rounded dividends
      tl10_q   <= '{ok: ok_c, sx: sx9_q, sy: sy9_q, col: sb9_q.col, row: sb9_q.row};
      den10_q  <= den9_q;
      numx10_q <= (NUM_W'(mx9_q) << FRAC_BITS) + NUM_W'(den9_q >> 1);
      numy10_q <= (NUM_W'(my9_q) << FRAC_BITS) + NUM_W'(den9_q >> 1);
      // Divider sideband
      tld_q[0] <= tl10_q;
      for (int s = 1; s < FRAC_BITS; s++) tld_q[s] <= tld_q[s-1];
      // Output register
      pv_q <= tld_q[FRAC_BITS-1].ok;
      cx_q <= tld_q[FRAC_BITS-1].ok
              ? (OUT_BITS'(tld_q[FRAC_BITS-1].col) << FRAC_BITS) + ox_c : '0;
      cy_q <= tld_q[FRAC_BITS-1].ok
              ? (OUT_BITS'(tld_q[FRAC_BITS-1].row) << FRAC_BITS) + oy_c : '0;
    end
  end

  // Signed offsets from the quotients
  always_comb begin
    ox_c = tld_q[FRAC_BITS-1].sx ? -$signed(OUT_BITS'(qx)) : $signed(OUT_BITS'(qx));
    oy_c = tld_q[FRAC_BITS-1].sy ? -$signed(OUT_BITS'(qy)) : $signed(OUT_BITS'(qy));
  end

  slp_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (adv),
    .rad_i  (rad_q),
    .root_o (root)
  );

  slp_div u_div_x (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (numx10_q),
    .den_i (den10_q),
    .quo_o (qx)
  );

  slp_div u_div_y (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (numy10_q),
    .den_i (den10_q),
    .quo_o (qy)
  );

  assign out_valid_o   = vo_q;
  assign point_valid_o = pv_q;
  assign center_x_o    = cx_q;
  assign center_y_o    = cy_q;

endmodule

// ----- dv/slp_checker.sv -----
// Checker for the Steger line-center block: predicts each pixel's center and compares results.
// Depends on slp_pkg; instantiated by tb_top beside the block.
`timescale 1ns / 1ps
module slp_checker import slp_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_valid_i,
  input  logic                       cfg_ready_i,
  input  logic [INT_W-1:0]           cfg_data_i,
  input  logic                       in_valid_i,
  input  logic                       in_stall_i,
  input  logic [INT_W-1:0]           intensity_i,
  input  logic [COORD_BITS-1:0]      column_i,
  input  logic [COORD_BITS-1:0]      row_i,
  input  logic signed [GRAD_W-1:0]   grad_x_i,
  input  logic signed [GRAD_W-1:0]   grad_y_i,
  input  logic signed [SEC_W-1:0]    second_xx_i,
  input  logic signed [SEC_W-1:0]    second_yy_i,
  input  logic signed [SEC_W-1:0]    second_xy_i,
  input  logic                       out_valid_i,
  input  logic                       out_stall_i,
  input  logic                       point_valid_i,
  input  logic signed [OUT_BITS-1:0] center_x_i,
  input  logic signed [OUT_BITS-1:0] center_y_i,
  output int                         errors_o,
  output int                         pending_o
);

  typedef struct packed {
    logic                       hit;
    logic signed [OUT_BITS-1:0] cx;
    logic signed [OUT_BITS-1:0] cy;
  } center_t;

  center_t           center_q[$];
  logic [INT_W-1:0]  thresh;

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint root64(longint x);
    longint r;
    r = 0;
    for (int k = 31; k >= 0; k--) begin
      if ((r + (64'sd1 << k)) * (r + (64'sd1 << k)) <= x) r = r + (64'sd1 << k);
    end
    return r;
  endfunction

  function automatic longint rnd_div(longint n, longint d);
    longint m;
    m = (mag(n) + d / 2) / d;
    return n < 0 ? -m : m;
  endfunction

  // Compute the expected center of one pixel
  function automatic center_t find_center(logic [INT_W-1:0] inten, logic [COORD_BITS-1:0] col,
      logic [COORD_BITS-1:0] rw, longint gx, longint gy, longint a, longint c, longint b);
    center_t r;
    longint vx, vy, p, q, nx, ny, s, sum, lam2, d;
    r = '0;
    if (inten <= thresh) return r;
    if (b == 0) begin
      if (mag(a) > mag(c) || (mag(a) == mag(c) && a >= c)) begin
        vx = VEC_HALF; vy = 0;
      end else begin
        vx = 0; vy = VEC_HALF;
      end
    end else begin
      d = (a - c) * (a - c) + 4 * b * b;
      s = root64(d << (2 * SQRT_GUARD));
      sum = a + c;
      lam2 = sum * (64'sd1 << SQRT_GUARD);
      lam2 = (sum >= 0) ? lam2 + s : lam2 - s;
      vx = b * (64'sd2 << SQRT_GUARD);
      vy = lam2 - a * (64'sd2 << SQRT_GUARD);
      while (mag(vx) >= 2 * VEC_HALF || mag(vy) >= 2 * VEC_HALF) begin
        vx = vx / 2; vy = vy / 2;
      end
    end
    p = vx * gx + vy * gy;
    q = vx * vx * a + 2 * vx * vy * b + vy * vy * c;
    if (q == 0) return r;
    nx = -p * vx;
    ny = -p * vy;
    if (q < 0) begin
      q = -q; nx = -nx; ny = -ny;
    end
    if (2 * mag(nx) > q || 2 * mag(ny) > q) return r;
    r.hit = 1'b1;
    r.cx = OUT_BITS'(longint'(col) * (1 << FRAC_BITS) + rnd_div(nx * (1 << FRAC_BITS), q));
    r.cy = OUT_BITS'(longint'(rw) * (1 << FRAC_BITS) + rnd_div(ny * (1 << FRAC_BITS), q));
    return r;
  endfunction

  assign pending_o = center_q.size();

  // Track threshold, predict on input transfer, compare on output transfer
  always @(posedge clk_i or negedge rst_ni) begin
    center_t e;
    if (!rst_ni) begin
      thresh   <= THRESH_RESET;
      errors_o <= 0;
      center_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) thresh <= cfg_data_i;
      if (in_valid_i && !in_stall_i)
        center_q = {center_q, find_center(intensity_i, column_i, row_i, grad_x_i, grad_y_i,
                                          second_xx_i, second_yy_i, second_xy_i)};
      if (out_valid_i && !out_stall_i) begin
        if (center_q.size() == 0) begin
          $display("%0t: unexpected result %b %0d %0d", $time, point_valid_i,
                   center_x_i, center_y_i);
          errors_o <= errors_o + 1;
        end else begin
          e = center_q.pop_front();
          if (e.hit !== point_valid_i || e.cx !== center_x_i || e.cy !== center_y_i) begin
            $display("%0t: expected %b %0d %0d, actual %b %0d %0d", $time, e.hit, e.cx,
                     e.cy, point_valid_i, center_x_i, center_y_i);
            errors_o <= errors_o + 1;
          end
        end
      end
    end
  end

endmodule

// ----- dv/tb_top.sv -----
// Testbench top for steger_subpixel_line_point: drives pixels, threshold writes and receiver stalls.
// Depends on slp_pkg, the block and slp_checker.
`timescale 1ns / 1ps
module tb_top;
  import slp_pkg::*;

  localparam int LATENCY = 29;

  logic clk_i, rst_ni;
  logic cfg_valid_i, cfg_ready_o;
  logic [INT_W-1:0] cfg_thresh;
  logic in_valid_i, in_stall_o;
  logic [INT_W-1:0] intensity_i;
  logic [COORD_BITS-1:0] column_i, row_i;
  logic signed [GRAD_W-1:0] grad_x_i, grad_y_i;
  logic signed [SEC_W-1:0] sxx, syy, sxy;
  logic out_valid_o, out_stall_i, point_valid_o;
  logic signed [OUT_BITS-1:0] center_x_o, center_y_o;
  int errors, pending;
  logic [INT_W-1:0] cur_thresh;

  steger_subpixel_line_point dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o,
    .cfg_intensity_threshold_i(cfg_thresh),
    .in_valid_i, .in_stall_o, .intensity_i, .column_i, .row_i,
    .grad_x_i, .grad_y_i, .second_xx_i(sxx), .second_yy_i(syy), .second_xy_i(sxy),
    .out_valid_o, .out_stall_i, .point_valid_o, .center_x_o, .center_y_o
  );

  slp_checker chk (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_data_i(cfg_thresh),
    .in_valid_i, .in_stall_i(in_stall_o), .intensity_i, .column_i, .row_i,
    .grad_x_i, .grad_y_i, .second_xx_i(sxx), .second_yy_i(syy), .second_xy_i(sxy),
    .out_valid_i(out_valid_o), .out_stall_i, .point_valid_i(point_valid_o),
    .center_x_i(center_x_o), .center_y_i(center_y_o), .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Random receiver stalls; a quiet stretch and a solid stall burst every so often
  initial begin
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      repeat ($urandom_range(1, 60)) begin
        @(posedge clk_i);
        out_stall_i <= ($urandom_range(0, 3) == 0);
      end
      @(posedge clk_i);
      out_stall_i <= 1'b0;
      repeat ($urandom_range(0, 80)) @(posedge clk_i);
      repeat (gap_len()) begin
        @(posedge clk_i);
        out_stall_i <= 1'b1;
      end
      @(posedge clk_i);
      out_stall_i <= 1'b0;
    end
  end

  // Present one pixel and hold it until transfer
  task automatic send_pixel(logic [7:0] it, logic [10:0] cx, logic [10:0] ry,
      logic signed [8:0] gx, logic signed [8:0] gy, logic signed [9:0] a,
      logic signed [9:0] c, logic signed [9:0] b);
    intensity_i <= it; column_i <= cx; row_i <= ry;
    grad_x_i <= gx; grad_y_i <= gy; sxx <= a; syy <= c; sxy <= b;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    if (gap_len() != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap_len()) @(posedge clk_i);
    end
  endtask

  // Drop valid right after the last transfer, then wait for every result
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic write_thresh(logic [7:0] v);
    cfg_thresh  <= v;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cur_thresh = v;
  endtask

  function automatic logic signed [9:0] sec_val(int mode);
    return mode == 0 ? 10'($signed($urandom_range(0, 1020)) - 510)
                     : 10'($signed($urandom_range(0, 60)) - 30);
  endfunction

  // Pixel brighter than the threshold with a ridge-like Hessian
  task automatic send_ridge();
    logic signed [9:0] a, c, b;
    logic signed [8:0] gx, gy;
    int r;
    r = $urandom_range(0, 9);
    a = sec_val(r < 3);
    c = sec_val(r < 3);
    b = (r == 9) ? 10'sd0 : sec_val(r < 5);
    if (r == 8) c = a;
    gx = 9'($signed($urandom_range(0, 510)) - 255);
    gy = 9'($signed($urandom_range(0, 510)) - 255);
    if ($urandom_range(0, 1)) begin
      gx = gx / 16; gy = gy / 16;
    end
    send_pixel((cur_thresh == 8'hFF) ? 8'hFF : 8'($urandom_range(cur_thresh + 1, 255)),
               11'($urandom), 11'($urandom), gx, gy, a, c, b);
  endtask

  initial begin
    rst_ni = 1'b0; cfg_valid_i = 1'b0; cfg_thresh = '0; in_valid_i = 1'b0;
    intensity_i = '0; column_i = '0; row_i = '0; grad_x_i = '0; grad_y_i = '0;
    sxx = '0; syy = '0; sxy = '0; cur_thresh = THRESH_RESET;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed: dark, threshold edge, axis cases, tie, zero curvature, extremes
    send_pixel(8'd200, 11'd5, 11'd5, 9'sd3, 9'sd3, -10'sd100, 10'sd0, 10'sd0);
    send_pixel(8'd201, 11'd5, 11'd5, 9'sd0, 9'sd0, -10'sd100, 10'sd0, 10'sd0);
    send_pixel(8'd255, 11'd0, 11'd0, 9'sd10, 9'sd0, -10'sd100, 10'sd5, 10'sd0);
    send_pixel(8'd255, 11'd2047, 11'd2047, 9'sd0, -9'sd10, 10'sd5, -10'sd100, 10'sd0);
    send_pixel(8'd255, 11'd7, 11'd9, 9'sd10, 9'sd10, 10'sd50, -10'sd50, 10'sd0);
    send_pixel(8'd255, 11'd7, 11'd9, 9'sd10, 9'sd10, -10'sd50, 10'sd50, 10'sd0);
    send_pixel(8'd255, 11'd7, 11'd9, 9'sd10, 9'sd10, 10'sd0, 10'sd0, 10'sd0);
    send_pixel(8'd255, 11'd1, 11'd1, 9'sd255, -9'sd255, -10'sd510, -10'sd510, 10'sd510);
    send_pixel(8'd255, 11'd1, 11'd1, -9'sd255, 9'sd255, 10'sd510, 10'sd510, -10'sd510);
    send_pixel(8'd255, 11'd1024, 11'd3, 9'sd5, 9'sd5, 10'sd510, -10'sd510, 10'sd510);
    send_pixel(8'd255, 11'd100, 11'd100, 9'sd200, 9'sd0, -10'sd10, 10'sd0, 10'sd0);
    send_pixel(8'd255, 11'd100, 11'd100, 9'sd1, 9'sd2, 10'sd300, 10'sd200, -10'sd100);
    drain();
    write_thresh(8'd0);
    send_pixel(8'd0, 11'd3, 11'd3, 9'sd1, 9'sd1, -10'sd20, 10'sd0, 10'sd0);
    send_pixel(8'd1, 11'd3, 11'd3, 9'sd1, 9'sd1, -10'sd20, 10'sd0, 10'sd0);
    drain();
    write_thresh(8'd255);
    send_pixel(8'd255, 11'd3, 11'd3, 9'sd1, 9'sd1, -10'sd20, 10'sd0, 10'sd0);
    drain();
    // Random phases at several thresholds; drains double as sender pauses
    for (int ph = 0; ph < 4; ph++) begin
      write_thresh(ph == 0 ? 8'd0 : ph == 3 ? 8'd254 : 8'($urandom));
      repeat (100) begin
        if ($urandom_range(0, 9) == 0)
          send_pixel(8'($urandom), 11'($urandom), 11'($urandom), 9'($urandom),
                     9'($urandom), 10'($urandom), 10'($urandom), 10'($urandom));
        else
          send_ridge();
      end
      drain();
    end
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_top: errors");
    $finish;
  end

endmodule
